// ----- rtl/core/bol_pkg.sv -----
package bol_pkg;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_DELETE    = 2'd2,
    OP_DUMP      = 2'd3
  } bol_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BADP  = 2'd3
  } bol_status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_DELETE,
    CMD_ROTATE
  } bol_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } bol_state_t;

  typedef struct packed {
    bol_cmd_t   cmd;
    logic [4:0] pos;
  } bol_bus_t;

  localparam int DataW = 32;
  localparam int PosW  = 5;
  localparam int CountOutW = 5;

endpackage

// ----- rtl/core/bol_cell.sv -----
module bol_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                    clk,
  input  bol_pkg::bol_bus_t       bus,
  input  logic [CW-1:0]           count,
  input  logic [bol_pkg::DataW-1:0] new_value,
  input  logic [bol_pkg::DataW-1:0] left_value,
  input  logic [bol_pkg::DataW-1:0] right_value,
  input  logic [bol_pkg::DataW-1:0] wrap_value,
  output logic [bol_pkg::DataW-1:0] value
);
  import bol_pkg::*;

  logic [DataW-1:0] value_next;

  always_comb begin
    value_next = value;
    case (bus.cmd)
      CMD_PUSH_FRONT: begin
        value_next = (IDX == 0) ? new_value : left_value;
      end
      CMD_PUSH_BACK: begin
        if (int'(count) == IDX) begin
          value_next = new_value;
        end
      end
      CMD_DELETE: begin
        if (int'(bus.pos) <= IDX + 1) begin
          value_next = right_value;
        end
      end
      CMD_ROTATE: begin
        value_next = (int'(count) == IDX + 1) ? wrap_value : right_value;
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- rtl/core/bounded_ordered_list_engine_unit.sv -----
// insert and delete: result registered in the cycle after the transfer, one item per cycle
// while the output is not stalled; dump: one result per held element, one per cycle while
// the output is not stalled, first result registered from the dump state; a dump holds the
// input off while the cell row rotates the list past cell zero and while the output stalls
// rst clears the count, the control state and the output valid; cell contents are not reset
module bounded_ordered_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], position[36:32], zero pad
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // element[31:0], count[36:32], zero pad
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  output logic        m_axis_tlast
);
  import bol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  bol_state_t       state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    dump_idx, dump_idx_next;
  bol_bus_t         bus;
  logic             out_free;
  logic             out_load;
  bol_status_t      out_status;
  logic [DataW-1:0] out_element;
  logic             out_last;
  logic             dump_end;

  bol_op_t          in_opcode;
  logic [DataW-1:0] in_value;
  logic [PosW-1:0]  in_pos;

  logic             m_valid;
  bol_status_t      m_status;
  logic [DataW-1:0] m_element;
  logic [CountOutW-1:0] m_count;
  logic             m_last;

  logic [DataW-1:0] cell_value [CAPACITY];

  assign in_opcode = bol_op_t'(s_axis_tuser);
  assign in_value  = s_axis_tdata[31:0];
  assign in_pos    = s_axis_tdata[36:32];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      bol_cell #(
        .IDX (g),
        .CW  (CW)
      ) u_cell (
        .clk         (clk),
        .bus         (bus),
        .count       (count),
        .new_value   (in_value),
        .left_value  ((g == 0) ? in_value : cell_value[(g == 0) ? 0 : g - 1]),
        .right_value ((g == CAPACITY - 1) ? cell_value[0]
                                          : cell_value[(g == CAPACITY - 1) ? g : g + 1]),
        .wrap_value  (cell_value[0]),
        .value       (cell_value[g])
      );
    end
  endgenerate

  assign out_free = !m_valid || m_axis_tready;
  assign dump_end = (dump_idx == count - CW'(1));

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    bus.cmd       = CMD_HOLD;
    bus.pos       = in_pos;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    out_status    = STAT_OK;
    out_element   = '0;
    out_last      = 1'b1;
    case (state)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (s_axis_tvalid && out_free) begin
          out_load = 1'b1;
          case (in_opcode)
            OP_INS_FRONT, OP_INS_BACK: begin
              if (int'(count) >= CAPACITY) begin
                out_status = STAT_FULL;
              end else begin
                bus.cmd    = (in_opcode == OP_INS_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                count_next = count + CW'(1);
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                out_status = STAT_EMPTY;
              end else if (in_pos == '0 || int'(in_pos) > int'(count)) begin
                out_status = STAT_BADP;
              end else begin
                bus.cmd    = CMD_DELETE;
                count_next = count - CW'(1);
              end
            end
            OP_DUMP: begin
              if (count == '0) begin
                out_status = STAT_EMPTY;
              end else begin
                out_load      = 1'b0;
                dump_idx_next = '0;
                state_next    = ST_DUMP;
              end
            end
            default: begin
              out_status = STAT_OK;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_element   = cell_value[0];
          out_last      = dump_end;
          bus.cmd       = CMD_ROTATE;
          dump_idx_next = dump_idx + CW'(1);
          if (dump_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      dump_idx <= '0;
      m_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_status  <= out_status;
      m_element <= out_element;
      m_count   <= CountOutW'(count_next);
      m_last    <= out_last;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {3'b000, m_count, m_element};
  assign m_axis_tuser  = m_status;
  assign m_axis_tlast  = m_last;

`ifndef ASSERT_OFF
  a_status_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && in_opcode != OP_DUMP |=> m_axis_tvalid)
    else $error("no result after insert or delete transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("count above capacity");

  a_dump_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> dump_idx < count)
    else $error("dump index past count");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && in_opcode == OP_INS_BACK && int'(count) < CAPACITY
    |=> count == $past(count) + CW'(1))
    else $error("count not advanced on insert");
`endif

endmodule

// ----- tb/tb_bounded_ordered_list_engine_unit.sv -----
module tb_bounded_ordered_list_engine_unit;
  import bol_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 443;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    bol_status_t status;
    logic [31:0] element;
    logic [4:0]  count;
    logic        is_last;
  } list_result_t;

  typedef struct {
    bol_op_t     op;
    logic [31:0] value;
    logic [4:0]  pos;
    bit          typed;
    bol_status_t status;
    logic [4:0]  count;
  } list_cmd_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // value[31:0], position[36:32], zero pad
  logic [1:0]  s_axis_tuser = '0;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // element[31:0], count[36:32], zero pad
  logic [1:0]  m_axis_tuser;       // status[1:0]
  logic        m_axis_tlast;

  logic [31:0]  held_cells[$];
  list_result_t pending_results[$];
  int           fail_count = 0;
  int           accepted_items = 0;
  int           cycle_count = 0;
  int           burst_left = 0;

  // directed rows: list is empty after reset
  list_cmd_row_t directed_rows [27] = '{
    '{OP_DUMP,      32'h0000_0000, 5'd0,  1'b1, STAT_EMPTY, 5'd0},
    '{OP_DELETE,    32'h0000_0000, 5'd1,  1'b1, STAT_EMPTY, 5'd0},
    '{OP_INS_BACK,  32'h7fff_ffff, 5'd0,  1'b1, STAT_OK,    5'd1},
    '{OP_DELETE,    32'h0000_0000, 5'd0,  1'b1, STAT_BADP,  5'd1},
    '{OP_DELETE,    32'h0000_0000, 5'd2,  1'b1, STAT_BADP,  5'd1},
    '{OP_DELETE,    32'hffff_ffff, 5'd1,  1'b1, STAT_OK,    5'd0},
    '{OP_INS_FRONT, 32'h8000_0000, 5'd31, 1'b1, STAT_OK,    5'd1},
    '{OP_INS_FRONT, 32'hffff_ffff, 5'd0,  1'b1, STAT_OK,    5'd2},
    '{OP_INS_BACK,  32'h0000_0000, 5'd16, 1'b1, STAT_OK,    5'd3},
    '{OP_DUMP,      32'hffff_ffff, 5'd31, 1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'h0000_0001, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_FRONT, 32'h5555_5555, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'haaaa_aaaa, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_FRONT, 32'h7fff_fffe, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'h8000_0001, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_FRONT, 32'h1234_5678, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'hfedc_ba98, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_FRONT, 32'h0f0f_0f0f, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'hf0f0_f0f0, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_FRONT, 32'h0000_0100, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'hdead_0001, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_FRONT, 32'h0001_0000, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'hffff_fffe, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_INS_BACK,  32'h0000_0002, 5'd0,  1'b1, STAT_FULL,  5'd16},
    '{OP_DUMP,      32'h0000_0000, 5'd0,  1'b0, STAT_OK,    5'd0},
    '{OP_DELETE,    32'h0000_0000, 5'd31, 1'b1, STAT_BADP,  5'd16},
    '{OP_DELETE,    32'h0000_0000, 5'd16, 1'b0, STAT_OK,    5'd0}
  };

  bounded_ordered_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_result(input bit record, input bol_status_t status,
                             input logic [31:0] element, input int count,
                             input logic is_last);
    list_result_t r;
    if (record) begin
      r.status  = status;
      r.element = element;
      r.count   = count[4:0];
      r.is_last = is_last;
      pending_results.push_back(r);
    end
  endtask

  // list behavior: updates the held cells and, when record is set, queues the results of one command
  task automatic apply_list_op(input bol_op_t op, input logic [31:0] value,
                               input logic [4:0] pos, input bit record);
    int sz;
    sz = held_cells.size();
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (sz >= CAPACITY) begin
          push_result(record, STAT_FULL, '0, sz, 1'b1);
        end else begin
          if (op == OP_INS_FRONT) held_cells.push_front(value);
          else held_cells.push_back(value);
          push_result(record, STAT_OK, '0, sz + 1, 1'b1);
        end
      end
      OP_DELETE: begin
        if (sz == 0) begin
          push_result(record, STAT_EMPTY, '0, 0, 1'b1);
        end else if (pos == 0 || int'(pos) > sz) begin
          push_result(record, STAT_BADP, '0, sz, 1'b1);
        end else begin
          held_cells.delete(int'(pos) - 1);
          push_result(record, STAT_OK, '0, sz - 1, 1'b1);
        end
      end
      default: begin
        if (sz == 0) begin
          push_result(record, STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < sz; i++)
            push_result(record, STAT_OK, held_cells[i], sz, i == sz - 1);
        end
      end
    endcase
  endtask

  task automatic send_cmd(input bol_op_t op, input logic [31:0] value,
                          input logic [4:0] pos, input bit typed,
                          input bol_status_t status, input logic [4:0] count);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pos, value};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    accepted_items++;
    apply_list_op(op, value, pos, !typed);
    if (typed) push_result(1'b1, status, '0, count, 1'b1);
    // sender bursts with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    bol_op_t     op;
    logic [31:0] value;
    logic [4:0]  pos;
    int          sz;
    int          r;
    int          mix;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
               directed_rows[i].typed, directed_rows[i].status, directed_rows[i].count);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sz  = held_cells.size();
      mix = (n / 40) % 3;
      r   = $urandom_range(0, 99);
      // fill, drain and mixed phases so the list swings between empty and full
      if (r < 15) op = OP_DUMP;
      else if (r < ((mix == 0) ? 80 : (mix == 1) ? 40 : 55))
        op = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
      else op = OP_DELETE;
      case ($urandom_range(0, 9))
        0: value = 32'h7fff_ffff;
        1: value = 32'h8000_0000;
        2: value = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
        default: value = $urandom;
      endcase
      r = $urandom_range(0, 9);
      if (sz > 0 && r < 7) pos = 5'($urandom_range(1, sz));
      else if (r == 7) pos = 5'd0;
      else if (r == 8) pos = 5'(sz + 1);
      else pos = 5'($urandom_range(0, 31));
      send_cmd(op, value, pos, 1'b0, STAT_OK, 5'd0);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver stall patterns, plus one long hold-off to back up the input
  initial begin
    int  tick;
    int  mode;
    int  hold_left;
    bit  held;
    bit  ready_next;
    tick      = 0;
    mode      = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!held && accepted_items >= HOLD_AFTER) begin
        held       = 1'b1;
        hold_left  = HOLD_CYCLES;
        ready_next = 1'b0;
      end else begin
        case (mode)
          0: ready_next = 1'b1;
          1: ready_next = $urandom_range(0, 1);
          2: ready_next = ($urandom_range(0, 3) == 0);
          default: ready_next = (tick % 5) < 3;
        endcase
      end
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      m_axis_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d element %h count %0d last %b",
               m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32], m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[31:0] !== want.element) begin
          $error("element: expected %h, actual %h", want.element, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[36:32] !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, m_axis_tdata[36:32]);
          fail_count++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("last: expected %b, actual %b", want.is_last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/core/bol_pkg.sv
rtl/core/bol_cell.sv
rtl/core/bounded_ordered_list_engine_unit.sv
tb/tb_bounded_ordered_list_engine_unit.sv
